// File: src/ipag_pkg.sv
// shared types and constants for the adaptive-gain incremental pid controller
package ipag_pkg;

	// default build values
	localparam int GAIN_FRAC_BITS_DEF = 12;
	localparam int SAMPLE_WIDTH_DEF   = 16;

	// fixed field widths
	localparam int GAIN_W      = 16;
	localparam int DRIVE_W     = 14;
	localparam int OUT_TDATA_W = 16;
	localparam int CFG_INDEX_W = 2;

	// gain schedule knees and limits, in whole units
	localparam int ERR_LOW_KNEE   = 500;
	localparam int ERR_HIGH_KNEE  = 2000;
	localparam int KNEE_SPAN      = 1500;
	localparam int KNEE_W         = 11;
	localparam int STEP_LIMIT_INT = 300;
	localparam int OUT_LIMIT_INT  = 7000;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TARGET = 2'd0,
		REG_KI     = 2'd1,
		REG_KD     = 2'd2
	} reg_index_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_DIFF,
		ST_KNUM,
		ST_KDIV,
		ST_KQ,
		ST_KFIX,
		ST_MP,
		ST_MI,
		ST_MD,
		ST_SUM,
		ST_CLAMP,
		ST_ACC,
		ST_RND,
		ST_OUT
	} seq_state_t;

endpackage

// File: src/ipag_mul.sv
// shared signed multiplier with registered product
module ipag_mul #(
	parameter int A_W = 28,
	parameter int B_W = 20
) (
	input  logic                        clk,
	input  logic signed [A_W-1:0]       a,
	input  logic signed [B_W-1:0]       b,
	output logic signed [A_W+B_W-1:0]   prod_q
);

	// one product per cycle, registered
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

// File: src/incremental_pid_adaptive_gain.sv
// top level of the incremental pid controller with error-scheduled kp
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid / tready    tuser: command, tdata: feedback
//  m_*       out  tvalid / tready    tdata: drive
//  cfg_*     in   cfg_wen            cfg_index, cfg_data
//
// a sample beat runs the full state sequence; a clear beat goes straight to the
// output state. the sequence is set by the one shared multiplier, which forms
// the kp interpolation (three products) and the three gain terms in turn.
// s_tready is high only in idle; the block then waits until the result beat is
// taken. reset clears the error history, the kept output and the registers.
module incremental_pid_adaptive_gain #(
	parameter int GAIN_FRAC_BITS = ipag_pkg::GAIN_FRAC_BITS_DEF,
	parameter int SAMPLE_WIDTH   = ipag_pkg::SAMPLE_WIDTH_DEF,
	localparam int CFG_DATA_W = (SAMPLE_WIDTH > ipag_pkg::GAIN_W) ?
		SAMPLE_WIDTH : ipag_pkg::GAIN_W,
	localparam int IN_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_wen,
	input  logic [ipag_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]                cfg_data,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [IN_TDATA_W-1:0]                s_tdata,   // feedback
	input  logic                                 s_tuser,   // command
	// output stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [ipag_pkg::OUT_TDATA_W-1:0]     m_tdata    // drive
);
	import ipag_pkg::*;

	localparam int F  = GAIN_FRAC_BITS;
	localparam int W  = SAMPLE_WIDTH;
	localparam int EW = W + 2;
	localparam int XW = W + 3;
	localparam int MW = (EW > 12) ? EW : 12;

	localparam longint ONE_Q   = longint'(1) << F;
	localparam longint KP_LO_V = (3 * ONE_Q + 5) / 10;
	localparam longint KP_HI_V = (7 * ONE_Q + 5) / 10;

	// reciprocal of the knee span, exact to within one after the shift
	localparam int     KNUM_W = F + KNEE_W;
	localparam int     SH     = F + 13;
	localparam int     RCW    = F + 3;
	localparam longint RCP_V  = (longint'(1) << SH) / KNEE_SPAN;

	localparam int MA0 = (KNUM_W > GAIN_W) ? KNUM_W : GAIN_W;
	localparam int MA  = MA0 + 1;
	localparam int MB0 = (XW > RCW + 1) ? XW : RCW + 1;
	localparam int MB  = (MB0 > KNEE_W + 1) ? MB0 : KNEE_W + 1;
	localparam int PW  = MA + MB;

	localparam int DW = ((F > GAIN_W) ? F : GAIN_W) + W + 5;
	localparam int AW = F + 14;
	localparam int SW = AW + 1;

	localparam logic [F-1:0]           KP_LO    = F'(KP_LO_V);
	localparam logic [F-1:0]           KP_HI    = F'(KP_HI_V);
	localparam logic [F-1:0]           KP_DIFF  = F'(KP_HI_V - KP_LO_V);
	localparam logic signed [DW-1:0]   STEP_POS = DW'(longint'(STEP_LIMIT_INT) * ONE_Q);
	localparam logic signed [DW-1:0]   STEP_NEG = DW'(-(longint'(STEP_LIMIT_INT) * ONE_Q));
	localparam logic signed [SW-1:0]   OUT_POS  = SW'(longint'(OUT_LIMIT_INT) * ONE_Q);
	localparam logic signed [SW-1:0]   OUT_NEG  = SW'(-(longint'(OUT_LIMIT_INT) * ONE_Q));
	localparam logic [AW-1:0]          FRAC_ONES = AW'(ONE_Q - 1);

	seq_state_t state_q, state_nx;

	// configuration registers
	logic signed [W-1:0]      target_q;
	logic [GAIN_W-1:0]        ki_q;
	logic [GAIN_W-1:0]        kd_q;

	// controller history
	logic signed [EW-1:0]     e1_q;
	logic signed [EW-1:0]     e2_q;
	logic signed [AW-1:0]     acc_q;

	// working registers
	logic signed [W-1:0]      fb_q;
	logic signed [EW-1:0]     e_q;
	logic signed [XW-1:0]     dp_q;
	logic signed [XW-1:0]     dd_q;
	logic [KNEE_W-1:0]        m_q;
	logic                     ramp_q;
	logic                     hi_q;
	logic [KNUM_W-1:0]        num_q;
	logic [F-1:0]             q0_q;
	logic [F-1:0]             kp_q;
	logic signed [DW-1:0]     d_q;
	logic signed [AW-1:0]     dcl_q;
	logic signed [DRIVE_W-1:0] drive_q;

	// shared multiplier
	logic signed [MA-1:0]     mul_a;
	logic signed [MB-1:0]     mul_b;
	logic signed [PW-1:0]     prod_q;

	// combinational helpers
	logic signed [MW-1:0]     e_w;
	logic [MW-1:0]            mag;
	logic                     in_ramp;
	logic [KNUM_W-1:0]        rem;
	logic                     corr;
	logic signed [SW-1:0]     acc_sum;
	logic signed [AW-1:0]     acc_rnd;

	ipag_mul #(
		.A_W (MA),
		.B_W (MB)
	) u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			ki_q     <= '0;
			kd_q     <= '0;
		end else if (cfg_wen) begin
			unique case (reg_index_t'(cfg_index))
				REG_TARGET: target_q <= cfg_data[W-1:0];
				REG_KI:     ki_q     <= cfg_data[GAIN_W-1:0];
				REG_KD:     kd_q     <= cfg_data[GAIN_W-1:0];
				default:    ;
			endcase
		end
	end

	// sequencer next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_nx = s_tuser ? ST_OUT : ST_ERR;
			ST_ERR:   state_nx = ST_DIFF;
			ST_DIFF:  state_nx = ST_KNUM;
			ST_KNUM:  state_nx = ST_KDIV;
			ST_KDIV:  state_nx = ST_KQ;
			ST_KQ:    state_nx = ST_KFIX;
			ST_KFIX:  state_nx = ST_MP;
			ST_MP:    state_nx = ST_MI;
			ST_MI:    state_nx = ST_MD;
			ST_MD:    state_nx = ST_SUM;
			ST_SUM:   state_nx = ST_CLAMP;
			ST_CLAMP: state_nx = ST_ACC;
			ST_ACC:   state_nx = ST_RND;
			ST_RND:   state_nx = ST_OUT;
			ST_OUT:   if (m_tready) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// sequencer outputs: handshakes and multiplier operands
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = (state_q == ST_OUT);
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_KNUM: begin
				mul_a = MA'(KP_DIFF);
				mul_b = MB'(m_q);
			end
			ST_KDIV: begin
				mul_a = MA'(prod_q[KNUM_W-1:0]);
				mul_b = MB'(RCP_V);
			end
			ST_KQ: begin
				mul_a = MA'(prod_q[SH+F-1:SH]);
				mul_b = MB'(KNEE_SPAN);
			end
			ST_MP: begin
				mul_a = MA'(kp_q);
				mul_b = MB'(dp_q);
			end
			ST_MI: begin
				mul_a = MA'(ki_q);
				mul_b = MB'(e_q);
			end
			ST_MD: begin
				mul_a = MA'(kd_q);
				mul_b = MB'(dd_q);
			end
			default: ;
		endcase
	end

	// error magnitude and schedule region
	always_comb begin
		e_w     = MW'(e_q);
		mag     = e_w[MW-1] ? MW'(-e_w) : MW'(e_w);
		in_ramp = (mag >= MW'(ERR_LOW_KNEE)) && (mag <= MW'(ERR_HIGH_KNEE));
	end

	// remainder check for the reciprocal quotient
	always_comb begin
		rem  = num_q - prod_q[KNUM_W-1:0];
		corr = (rem >= KNUM_W'(KNEE_SPAN));
	end

	// accumulate and round toward zero
	always_comb begin
		acc_sum = SW'(acc_q) + SW'(dcl_q);
		acc_rnd = acc_q[AW-1] ? (acc_q + FRAC_ONES) : acc_q;
	end

	// controller history: clear command and end-of-sample update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q  <= '0;
			e2_q  <= '0;
			acc_q <= '0;
		end else if (state_q == ST_IDLE && s_tvalid && s_tuser) begin
			e1_q  <= '0;
			e2_q  <= '0;
			acc_q <= '0;
		end else if (state_q == ST_ACC) begin
			e2_q <= e1_q;
			e1_q <= e_q;
			if (acc_sum > OUT_POS) begin
				acc_q <= AW'(OUT_POS);
			end else if (acc_sum < OUT_NEG) begin
				acc_q <= AW'(OUT_NEG);
			end else begin
				acc_q <= AW'(acc_sum);
			end
		end
	end

	// working datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					fb_q    <= s_tdata[W-1:0];
					drive_q <= '0;
				end
			end
			ST_ERR: begin
				e_q <= EW'(target_q) - EW'(fb_q);
			end
			ST_DIFF: begin
				dp_q   <= XW'(e_q) - XW'(e1_q);
				dd_q   <= XW'(e_q) - (XW'(e1_q) <<< 1) + XW'(e2_q);
				ramp_q <= in_ramp;
				hi_q   <= (mag > MW'(ERR_HIGH_KNEE));
				m_q    <= in_ramp ? KNEE_W'(mag - MW'(ERR_LOW_KNEE)) : '0;
			end
			ST_KDIV: begin
				num_q <= prod_q[KNUM_W-1:0];
			end
			ST_KQ: begin
				q0_q <= prod_q[SH+F-1:SH];
			end
			ST_KFIX: begin
				priority if (ramp_q) begin
					kp_q <= KP_LO + q0_q + F'(corr);
				end else if (hi_q) begin
					kp_q <= KP_HI;
				end else begin
					kp_q <= KP_LO;
				end
			end
			ST_MI: begin
				d_q <= DW'(prod_q);
			end
			ST_MD, ST_SUM: begin
				d_q <= d_q + DW'(prod_q);
			end
			ST_CLAMP: begin
				if (d_q > STEP_POS) begin
					dcl_q <= AW'(STEP_POS);
				end else if (d_q < STEP_NEG) begin
					dcl_q <= AW'(STEP_NEG);
				end else begin
					dcl_q <= AW'(d_q);
				end
			end
			ST_RND: begin
				drive_q <= acc_rnd[AW-1:F];
			end
			default: ;
		endcase
	end

	// result beat, zero padded to whole bytes
	assign m_tdata = {{(OUT_TDATA_W - DRIVE_W){1'b0}}, drive_q};

endmodule

// File: bench/tb.sv
// self-checking bench for the adaptive-gain incremental pid controller
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ipag_pkg::*;

	localparam int  FRAC       = GAIN_FRAC_BITS_DEF;
	localparam int  SW         = SAMPLE_WIDTH_DEF;
	localparam int  BEATS_RAND = 125;
	localparam int  PHASES     = 10;
	localparam int  HOLD_LEN   = 400;
	localparam int  TAIL_WAIT  = 20;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
	localparam longint ONE_Q    = longint'(1) << FRAC;
	localparam longint KP_LO    = (3 * ONE_Q + 5) / 10;
	localparam longint KP_HI    = (7 * ONE_Q + 5) / 10;
	localparam longint STEP_LIM = STEP_LIMIT_INT * ONE_Q;
	localparam longint OUT_LIM  = OUT_LIMIT_INT * ONE_Q;

	typedef struct {
		bit                    clear;
		logic signed [SW-1:0]  feedback;
	} sample_beat_t;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        cfg_wen = 1'b0;
	logic [CFG_INDEX_W-1:0]      cfg_index = REG_TARGET;
	logic [15:0]                 cfg_data = '0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [15:0]                 s_tdata = '0;    // feedback
	logic                        s_tuser = 1'b0;  // command
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]      m_tdata;         // drive

	// controller copy: registers and history
	longint target_m, ki_m, kd_m;
	longint last_err, older_err, accum_q;

	sample_beat_t          sample_q[$];
	logic [DRIVE_W-1:0]    drive_q[$];
	int                    mismatch_count = 0;
	int                    tx_idle_pct = 0;
	int                    rx_idle_pct = 0;
	logic                  rx_hold_start = 1'b0;
	int                    hold_left = 0;

	incremental_pid_adaptive_gain dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// one controller step or clear: kp schedule, clamped increment, saturated output
	function automatic logic [DRIVE_W-1:0] predict_drive(bit clr, logic signed [SW-1:0] fb);
		longint e, mag, kp, d, whole;
		if (clr) begin
			last_err  = 0;
			older_err = 0;
			accum_q   = 0;
			return '0;
		end
		e   = target_m - longint'(fb);
		mag = (e < 0) ? -e : e;
		if (mag > ERR_HIGH_KNEE)
			kp = KP_HI;
		else if (mag < ERR_LOW_KNEE)
			kp = KP_LO;
		else
			kp = KP_LO + ((KP_HI - KP_LO) * (mag - ERR_LOW_KNEE)) / KNEE_SPAN;
		d = kp * (e - last_err) + ki_m * e + kd_m * (e - 2 * last_err + older_err);
		if (d > STEP_LIM)
			d = STEP_LIM;
		else if (d < -STEP_LIM)
			d = -STEP_LIM;
		accum_q   = accum_q + d;
		older_err = last_err;
		last_err  = e;
		if (accum_q > OUT_LIM)
			accum_q = OUT_LIM;
		if (accum_q < -OUT_LIM)
			accum_q = -OUT_LIM;
		whole = (accum_q >= 0) ? (accum_q >>> FRAC) : -((-accum_q) >>> FRAC);
		return whole[DRIVE_W-1:0];
	endfunction

	// sample source: mostly near the setpoint across the knees, some noise, extremes and clears
	function automatic sample_beat_t gen_sample();
		sample_beat_t b;
		int     r;
		longint v;
		r = $urandom_range(99);
		b.clear    = 1'b0;
		b.feedback = '0;
		if (r < 5) begin
			b.clear    = 1'b1;
			b.feedback = SW'($urandom);
		end else if (r < 70) begin
			v = target_m + longint'($urandom_range(5000)) - 2500;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			b.feedback = v[SW-1:0];
		end else if (r < 90) begin
			b.feedback = SW'($urandom);
		end else begin
			b.feedback = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
		end
		return b;
	endfunction

	task automatic push_sample(bit clr, logic signed [SW-1:0] fb);
		sample_beat_t b;
		b.clear    = clr;
		b.feedback = fb;
		sample_q.push_back(b);
	endtask

	// register write, only issued while the block is idle
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		case (idx)
			REG_TARGET: target_m = longint'($signed(val));
			REG_KI:     ki_m = longint'(val);
			REG_KD:     kd_m = longint'(val);
			default: ;
		endcase
		@(negedge clk);
	endtask

	// wait until every queued beat is sent and every drive beat has come back
	task automatic drain();
		do
			@(negedge clk);
		while (sample_q.size() != 0 || s_tvalid || drive_q.size() != 0);
	endtask

	task automatic write_all(logic [15:0] tgt, logic [15:0] ki, logic [15:0] kd);
		write_reg(REG_TARGET, tgt);
		write_reg(REG_KI, ki);
		write_reg(REG_KD, kd);
	endtask

	function automatic logic [15:0] pick_gain();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 16'h0000;
		else if (r == 1)
			return 16'hffff;
		else if (r < 7)
			return 16'($urandom_range(2048));
		return 16'($urandom);
	endfunction

	// driver: hold valid until accepted, predict on every accepted beat
	always @(posedge clk) begin
		sample_beat_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				drive_q.push_back(predict_drive(s_tuser, s_tdata));
			if (!s_tvalid || s_tready) begin
				if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					nxt = sample_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.feedback;
					s_tuser  <= nxt.clear;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (rx_hold_start)
			hold_left <= HOLD_LEN;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// monitor: compare each drive beat with the oldest prediction
	always @(posedge clk) begin
		logic [DRIVE_W-1:0] want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (drive_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: drive beat with nothing pending, expected none, actual %0d",
						$time, $signed(m_tdata[DRIVE_W-1:0]));
				end else begin
					want = drive_q.pop_front();
					if (m_tdata[DRIVE_W-1:0] !== want) begin
						mismatch_count++;
						$display("%0t: drive mismatch, expected %0d, actual %0d", $time,
							$signed(want), $signed(m_tdata[DRIVE_W-1:0]));
					end
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// stimulus sequence
	initial begin
		target_m  = 0;
		ki_m      = 0;
		kd_m      = 0;
		last_err  = 0;
		older_err = 0;
		accum_q   = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		tx_idle_pct = 16;
		rx_idle_pct = 51;

		// knees of the kp schedule in both signs, feedback extremes, clear
		write_all(16'h0000, 16'h0800, 16'h0400);
		write_reg(REG_SPARE, 16'hffff);
		push_sample(1'b0, 16'sd0);
		push_sample(1'b0, -16'sd499);
		push_sample(1'b0, -16'sd500);
		push_sample(1'b0, -16'sd501);
		push_sample(1'b0, -16'sd1250);
		push_sample(1'b0, -16'sd2000);
		push_sample(1'b0, -16'sd2001);
		push_sample(1'b0, 16'sd2000);
		push_sample(1'b0, 16'sd500);
		push_sample(1'b0, 16'sh7fff);
		push_sample(1'b0, 16'sh8000);
		push_sample(1'b1, 16'sh7fff);
		drain();

		// largest error with full gains: increment clamps
		write_all(16'h7fff, 16'hffff, 16'hffff);
		repeat (7) push_sample(1'b0, 16'sh8000);
		push_sample(1'b1, 16'sh8000);
		drain();
		write_reg(REG_TARGET, 16'h8000);
		repeat (4) push_sample(1'b0, 16'sh7fff);
		push_sample(1'b1, 16'sd0);
		drain();

		// random phases, fresh register set each phase
		for (int p = 0; p < PHASES; p++) begin
			if (p < 3) begin
				tx_idle_pct = 16;
				rx_idle_pct = 51;
			end else if (p < 6) begin
				tx_idle_pct = 51;
				rx_idle_pct = 16;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (p == 0)
				write_all(16'h7fff, 16'hffff, 16'h0000);
			else if (p == 1)
				write_all(16'h8000, 16'h0000, 16'hffff);
			else
				write_all($urandom_range(3) == 0 ? 16'h8000 : 16'($urandom),
					pick_gain(), pick_gain());
			if (p == 5)
				write_reg(REG_SPARE, 16'($urandom));
			for (int i = 0; i < BEATS_RAND; i++)
				sample_q.push_back(gen_sample());
			if (p == 4) begin
				@(posedge clk);
				rx_hold_start <= 1'b1;
				@(posedge clk);
				rx_hold_start <= 1'b0;
				@(negedge clk);
			end
			drain();
		end

		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatch_count == 0 && drive_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
